// File: src/fstwa_pkg.sv
`timescale 1ns / 1ps
package fstwa_pkg;
	localparam int TW = 48;
	localparam int CW = 32;
	localparam logic [1:0] FUNC_ADVANCE  = 2'd0;
	localparam logic [1:0] FUNC_SCHEDULE = 2'd1;
	localparam logic [1:0] FUNC_UNSCHED  = 2'd2;
	localparam logic [1:0] FUNC_RESET    = 2'd3;
	localparam logic [1:0] KIND_ALARM  = 2'd0;
	localparam logic [1:0] KIND_TICK   = 2'd1;
	localparam logic [1:0] KIND_ACK    = 2'd2;
	localparam logic [1:0] KIND_UNSCH  = 2'd3;
	localparam logic [TW-1:0] MAX48 = {TW{1'b1}};

	// Token that walks the slot chain during a scan.
	typedef struct packed {
		logic          scan;
		logic [TW-1:0] elapsed;
	} scan_tok_t;

	// Command broadcast to every cell.
	typedef struct packed {
		logic          sched;
		logic          unsch;
		logic [5:0]    idx;
		logic          rep;
		logic [TW-1:0] stime;
		logic [TW-1:0] lfire;
	} cell_cmd_t;
endpackage

// File: src/fixed_step_timer_with_alarms_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tdata: func, now_time, slot_index, delay, repeating
// m_axis    out  m_axis_tvalid/tready      tdata: fired_slot..found; tuser: kind; tlast
// cfg       in   cfg_valid/cfg_ready       cfg_data: update_interval
// One item at a time. An advance first accumulates the time step, then a token walks the slot
// cells (one cell per cycle while the output register can take a result), then up to
// MAX_CATCHUP ticks are emitted, and then the final result is released.
// Alarms and ticks wait in a staging register so the final one can carry tlast.
// Other operations put their result in the output register the cycle after acceptance.
// A full output register holds the walk and the tick emission in place.
// Reset clears all control state and slot valid bits at once.
module fixed_step_timer_with_alarms_top #(
	parameter int NUM_SLOTS = 16,
	parameter int MAX_CATCHUP = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// func[1:0], now_time[49:2], slot_index[53:50], delay[85:54], repeating[86], pad
	input  logic [87:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// fired_slot[3:0], tick_number[35:4], elapsed_now[83:36], leftover[131:84], found[132]
	output logic [135:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser,   // kind
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);
	localparam int TW = fstwa_pkg::TW;
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int KW = $clog2(MAX_CATCHUP + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_TICK} state_t;
	state_t state_q;

	logic [31:0]   interval_q;
	logic [TW-1:0] acc_q, elapsed_q, prev_q, base_q;
	logic [31:0]   tick_q;
	logic [SW:0]   pos_q;
	logic [KW-1:0] nt_q;
	logic          obusy_q;
	logic [1:0]    okind_q;
	logic [3:0]    oslot_q;
	logic [31:0]   otick_q;
	logic [TW-1:0] oel_q, oleft_q;
	logic          ofound_q, olast_q;
	logic          sv_q;
	logic [1:0]    skind_q;
	logic [3:0]    sslot_q;
	logic [31:0]   stick_q;
	logic [TW-1:0] sel_q, sleft_q;

	fstwa_pkg::cell_cmd_t cmd;
	fstwa_pkg::scan_tok_t tok [NUM_SLOTS+1];
	logic [NUM_SLOTS-1:0] fire, used, used_sh;

	logic [1:0]    i_func;
	logic [TW-1:0] i_now;
	logic [3:0]    i_idx;
	logic [31:0]   i_delay;
	logic          i_rep;
	assign i_func  = s_axis_tdata[1:0];
	assign i_now   = s_axis_tdata[49:2];
	assign i_idx   = s_axis_tdata[53:50];
	assign i_delay = s_axis_tdata[85:54];
	assign i_rep   = s_axis_tdata[86];

	logic          acc_in, in_range, ofree, tick_go, scan_fire, scan_end;
	logic [TW+1:0] acc_sum;
	logic [TW:0]   dl_sum;
	logic [31:0]   ivl;
	logic [TW-1:0] el_new;
	assign ivl = (interval_q == 32'd0) ? 32'd1 : interval_q;
	assign ofree = !obusy_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && ofree;
	assign acc_in = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign in_range = {3'b000, i_idx} < 7'(NUM_SLOTS);
	assign used_sh = used >> i_idx;
	assign acc_sum = {2'b00, acc_q} + {2'b00, i_now} - {2'b00, prev_q};
	assign el_new = (i_now >= base_q) ? i_now - base_q : '0;
	assign dl_sum = {1'b0, elapsed_q} + {17'd0, i_delay};
	assign tick_go = (nt_q < KW'(MAX_CATCHUP)) && (acc_q > {16'd0, ivl});

	// Cells advance only when the output can take whatever they produce.
	logic step;
	assign step = (state_q == ST_SCAN) && ofree;
	assign tok[0].scan = step && (pos_q == '0);
	assign tok[0].elapsed = elapsed_q;

	always_comb begin
		cmd.sched = acc_in && i_func == fstwa_pkg::FUNC_SCHEDULE && in_range;
		cmd.unsch = acc_in && i_func == fstwa_pkg::FUNC_UNSCHED && in_range;
		cmd.idx = {2'b00, i_idx};
		cmd.rep = i_rep;
		cmd.stime = i_rep ? {16'd0, i_delay} : (dl_sum[TW] ? fstwa_pkg::MAX48 : dl_sum[TW-1:0]);
		cmd.lfire = i_rep ? elapsed_q : '0;
	end

	genvar g;
	generate
		for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
			fstwa_cell #(.IDX(g)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(step), .cmd(cmd), .tok_in(tok[g]),
				.tok_out(tok[g+1]), .fire(fire[g]), .used(used[g])
			);
		end
	endgenerate

	// The cell at the current position is the one the token sits in.
	logic [SW-1:0] cur;
	assign cur = pos_q[SW-1:0];
	assign scan_fire = step && fire[cur];
	assign scan_end = step && (pos_q == (SW+1)'(NUM_SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			interval_q <= 32'd16667;
			acc_q <= '0; elapsed_q <= '0; prev_q <= '0; base_q <= '0;
			tick_q <= '0; pos_q <= '0; nt_q <= '0; obusy_q <= 1'b0;
			okind_q <= '0; oslot_q <= '0; otick_q <= '0; oel_q <= '0;
			oleft_q <= '0; ofound_q <= 1'b0; olast_q <= 1'b0;
			sv_q <= 1'b0; skind_q <= '0; sslot_q <= '0; stick_q <= '0;
			sel_q <= '0; sleft_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				interval_q <= cfg_data;
			if (obusy_q && m_axis_tready)
				obusy_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						okind_q <= fstwa_pkg::KIND_ACK;
						oslot_q <= i_idx;
						otick_q <= '0;
						oel_q <= elapsed_q;
						oleft_q <= '0;
						ofound_q <= 1'b0;
						olast_q <= 1'b1;
						case (i_func)
							fstwa_pkg::FUNC_ADVANCE: begin
								if (acc_sum[TW+1])
									acc_q <= '0;
								else if (acc_sum[TW])
									acc_q <= fstwa_pkg::MAX48;
								else
									acc_q <= acc_sum[TW-1:0];
								prev_q <= i_now;
								elapsed_q <= el_new;
								pos_q <= '0;
								nt_q <= '0;
								sv_q <= 1'b0;
								state_q <= ST_SCAN;
							end
							fstwa_pkg::FUNC_SCHEDULE: obusy_q <= 1'b1;
							fstwa_pkg::FUNC_UNSCHED: begin
								okind_q <= fstwa_pkg::KIND_UNSCH;
								ofound_q <= in_range && used_sh[0];
								obusy_q <= 1'b1;
							end
							default: begin
								base_q <= i_now; prev_q <= i_now;
								elapsed_q <= '0; tick_q <= '0; acc_q <= '0;
								oslot_q <= '0; oel_q <= '0;
								obusy_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (step) begin
						if (scan_fire) begin
							// A new result pushes the staged one out; it cannot be the last.
							if (sv_q) begin
								okind_q <= skind_q; oslot_q <= sslot_q; otick_q <= stick_q;
								oel_q <= sel_q; oleft_q <= sleft_q;
								ofound_q <= 1'b0; olast_q <= 1'b0;
								obusy_q <= 1'b1;
							end
							skind_q <= fstwa_pkg::KIND_ALARM;
							sslot_q <= 4'(cur);
							stick_q <= '0; sel_q <= elapsed_q; sleft_q <= '0;
							sv_q <= 1'b1;
						end
						pos_q <= pos_q + 1'b1;
						if (scan_end)
							state_q <= ST_TICK;
					end
				end
				ST_TICK: begin
					if (ofree) begin
						if (tick_go) begin
							if (sv_q) begin
								okind_q <= skind_q; oslot_q <= sslot_q; otick_q <= stick_q;
								oel_q <= sel_q; oleft_q <= sleft_q;
								ofound_q <= 1'b0; olast_q <= 1'b0;
								obusy_q <= 1'b1;
							end
							skind_q <= fstwa_pkg::KIND_TICK;
							sslot_q <= '0; stick_q <= tick_q; sel_q <= elapsed_q;
							sleft_q <= acc_q;
							sv_q <= 1'b1;
							acc_q <= acc_q - {16'd0, ivl};
							tick_q <= tick_q + 32'd1;
							nt_q <= nt_q + 1'b1;
						end else begin
							// Release the staged result as the final one of this advance.
							if (sv_q) begin
								okind_q <= skind_q; oslot_q <= sslot_q; otick_q <= stick_q;
								oel_q <= sel_q; oleft_q <= sleft_q;
								ofound_q <= 1'b0; olast_q <= 1'b1;
								obusy_q <= 1'b1;
								sv_q <= 1'b0;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = obusy_q;
	assign m_axis_tuser = okind_q;
	assign m_axis_tlast = olast_q;
	assign m_axis_tdata = {3'd0, ofound_q, oleft_q, oel_q, otick_q, oslot_q};
endmodule

// File: src/fstwa_cell.sv
`timescale 1ns / 1ps
module fstwa_cell #(
	parameter int IDX = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  fstwa_pkg::cell_cmd_t   cmd,
	input  fstwa_pkg::scan_tok_t   tok_in,
	output fstwa_pkg::scan_tok_t   tok_out,
	output logic                   fire,
	output logic                   used
);
	logic                       used_q, fired_q, rep_q;
	logic [fstwa_pkg::TW-1:0]   time_q, last_q;
	fstwa_pkg::scan_tok_t       tok_q;
	logic                       due, hit;

	always_comb begin
		if (rep_q)
			due = (tok_in.elapsed >= last_q) && (tok_in.elapsed - last_q >= time_q);
		else
			due = time_q <= tok_in.elapsed;
		hit = en && tok_in.scan && used_q && (rep_q || !fired_q) && due;
	end

	// The token only moves on when the chain is enabled, so a stall holds it in place.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			fired_q <= 1'b0;
			tok_q <= '0;
		end else begin
			if (en)
				tok_q <= tok_in;
			if (cmd.sched && cmd.idx == 6'(IDX)) begin
				used_q <= 1'b1;
				fired_q <= 1'b0;
			end else if (cmd.unsch && cmd.idx == 6'(IDX)) begin
				used_q <= 1'b0;
			end else if (en && tok_in.scan && used_q) begin
				if (!rep_q && fired_q)
					used_q <= 1'b0;
				else if (hit)
					fired_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sched && cmd.idx == 6'(IDX)) begin
			rep_q <= cmd.rep;
			time_q <= cmd.stime;
			last_q <= cmd.lfire;
		end else if (hit) begin
			last_q <= tok_in.elapsed;
		end
	end

	assign tok_out = tok_q;
	assign fire = hit;
	assign used = used_q;
endmodule

// File: tb/tb_fixed_step_timer_with_alarms_top.sv
`timescale 1ns / 1ps
module tb_fixed_step_timer_with_alarms_top;
	typedef struct {
		logic [1:0]  func;
		logic [47:0] now;
		logic [3:0]  idx;
		logic [31:0] delay;
		logic        rep;
	} timer_op_t;

	typedef struct {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic [31:0] tick;
		logic [47:0] el;
		logic [47:0] left;
		logic        found;
		logic        last;
	} timer_res_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [87:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [135:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [31:0]  cfg_data = '0;

	fixed_step_timer_with_alarms_top dut (.*);

	always #5 clk = ~clk;

	// Model state of the timer.
	logic        m_used [16];
	logic        m_rep [16];
	logic [47:0] m_stime [16];
	logic        m_fired [16];
	logic [47:0] m_lfire [16];
	logic [47:0] m_accum, m_elapsed, m_prev_raw, m_base;
	logic [31:0] m_ticks, m_interval;

	timer_op_t  op_pending [$];
	timer_res_t results_due [$];
	timer_op_t  op_shown;
	int         fail_count = 0;
	int         in_gap = 0, out_stall = 0;
	bit         no_idle = 0;
	logic [47:0] gen_now = 0;
	longint      cycle_count = 0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (no_idle || r < 5) return 0;
		if (r < 9) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void push_res(ref timer_res_t q[$], input logic [1:0] kind,
			input logic [3:0] slot, input logic [31:0] tick, input logic [47:0] el,
			input logic [47:0] left, input logic found);
		timer_res_t r;
		r.kind = kind; r.slot = slot; r.tick = tick; r.el = el;
		r.left = left; r.found = found; r.last = 0;
		q.push_back(r);
	endfunction

	function automatic void predict_timer(timer_op_t o);
		timer_res_t q [$];
		longint a;
		logic [47:0] ivl;
		logic [48:0] t;
		logic due;
		case (o.func)
			fstwa_pkg::FUNC_ADVANCE: begin
				a = longint'({16'b0, m_accum}) + longint'({16'b0, o.now})
					- longint'({16'b0, m_prev_raw});
				if (a < 0) a = 0;
				if (a > longint'({16'b0, fstwa_pkg::MAX48})) a = longint'({16'b0, fstwa_pkg::MAX48});
				m_accum = a[47:0];
				m_prev_raw = o.now;
				m_elapsed = (o.now >= m_base) ? o.now - m_base : '0;
				ivl = (m_interval == 0) ? 48'd1 : {16'b0, m_interval};
				for (int i = 0; i < 16; i++) begin
					if (!m_used[i]) continue;
					if (!m_rep[i] && m_fired[i]) begin
						m_used[i] = 0;
						continue;
					end
					if (m_rep[i])
						due = m_elapsed >= m_lfire[i] && m_elapsed - m_lfire[i] >= m_stime[i];
					else
						due = m_stime[i] <= m_elapsed;
					if (!due) continue;
					m_lfire[i] = m_elapsed;
					m_fired[i] = 1;
					push_res(q, fstwa_pkg::KIND_ALARM, i[3:0], '0, m_elapsed, '0, 1'b0);
				end
				for (int k = 0; k < 16 && m_accum > ivl; k++) begin
					push_res(q, fstwa_pkg::KIND_TICK, '0, m_ticks, m_elapsed, m_accum, 1'b0);
					m_accum = m_accum - ivl;
					m_ticks = m_ticks + 32'd1;
				end
			end
			fstwa_pkg::FUNC_SCHEDULE: begin
				t = {1'b0, m_elapsed} + {17'b0, o.delay};
				m_used[o.idx] = 1;
				m_rep[o.idx] = o.rep;
				m_stime[o.idx] = o.rep ? {16'b0, o.delay} : (t[48] ? fstwa_pkg::MAX48 : t[47:0]);
				m_fired[o.idx] = 0;
				m_lfire[o.idx] = o.rep ? m_elapsed : '0;
				push_res(q, fstwa_pkg::KIND_ACK, o.idx, '0, m_elapsed, '0, 1'b0);
			end
			fstwa_pkg::FUNC_UNSCHED: begin
				push_res(q, fstwa_pkg::KIND_UNSCH, o.idx, '0, m_elapsed, '0, m_used[o.idx]);
				m_used[o.idx] = 0;
			end
			default: begin
				m_base = o.now;
				m_prev_raw = o.now;
				m_elapsed = 0;
				m_ticks = 0;
				m_accum = 0;
				push_res(q, fstwa_pkg::KIND_ACK, '0, '0, '0, '0, 1'b0);
			end
		endcase
		if (q.size() > 0) q[q.size() - 1].last = 1;
		foreach (q[i]) results_due.push_back(q[i]);
	endfunction

	// Input driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			in_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) predict_timer(op_shown);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (in_gap != 0) begin
					in_gap <= in_gap - 1;
					s_axis_tvalid <= 0;
				end else if (op_pending.size() > 0) begin
					op_shown <= op_pending[0];
					s_axis_tdata <= {1'b0, op_pending[0].rep, op_pending[0].delay,
						op_pending[0].idx, op_pending[0].now, op_pending[0].func};
					void'(op_pending.pop_front());
					s_axis_tvalid <= 1;
					in_gap <= pick_gap();
				end else begin
					s_axis_tvalid <= 0;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk or negedge arst_n) begin
		timer_res_t e;
		if (!arst_n) begin
			m_axis_tready <= 0;
			out_stall <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (results_due.size() == 0) begin
					$error("unexpected result kind %0d", m_axis_tuser);
					fail_count++;
				end else begin
					e = results_due.pop_front();
					if (m_axis_tuser !== e.kind) begin
						$error("kind: expected %0d, got %0d", e.kind, m_axis_tuser);
						fail_count++;
					end
					if (m_axis_tdata[3:0] !== e.slot) begin
						$error("fired_slot: expected %0d, got %0d", e.slot, m_axis_tdata[3:0]);
						fail_count++;
					end
					if (m_axis_tdata[35:4] !== e.tick) begin
						$error("tick_number: expected %0d, got %0d", e.tick, m_axis_tdata[35:4]);
						fail_count++;
					end
					if (m_axis_tdata[83:36] !== e.el) begin
						$error("elapsed_now: expected %0d, got %0d", e.el, m_axis_tdata[83:36]);
						fail_count++;
					end
					if (m_axis_tdata[131:84] !== e.left) begin
						$error("leftover: expected %0d, got %0d", e.left, m_axis_tdata[131:84]);
						fail_count++;
					end
					if (m_axis_tdata[132] !== e.found) begin
						$error("found: expected %0d, got %0d", e.found, m_axis_tdata[132]);
						fail_count++;
					end
					if (m_axis_tlast !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, m_axis_tlast);
						fail_count++;
					end
				end
			end
			if (out_stall != 0) begin
				out_stall <= out_stall - 1;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= 1;
				if (!no_idle && $urandom_range(0, 5) == 0) out_stall <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 1000000) begin
			$display("tb_fixed_step_timer_with_alarms_top failed");
			$finish;
		end
	end

	function automatic void add_op(logic [1:0] f, logic [47:0] now, logic [3:0] idx,
			logic [31:0] delay, logic rep);
		timer_op_t o;
		o.func = f; o.now = now; o.idx = idx; o.delay = delay; o.rep = rep;
		op_pending.push_back(o);
		if (f == fstwa_pkg::FUNC_ADVANCE || f == fstwa_pkg::FUNC_RESET) gen_now = now;
	endfunction

	function automatic void add_random_ops(int n);
		int r;
		logic [48:0] nx;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				nx = {1'b0, gen_now} + 49'($urandom_range(0, 60000));
				add_op(fstwa_pkg::FUNC_ADVANCE, nx[48] ? fstwa_pkg::MAX48 : nx[47:0],
					4'($urandom), $urandom, 1'($urandom));
			end else if (r < 48) begin
				add_op(fstwa_pkg::FUNC_ADVANCE, 48'({$urandom, $urandom}), 4'($urandom),
					$urandom, 1'($urandom));
			end else if (r < 51) begin
				add_op(fstwa_pkg::FUNC_ADVANCE, gen_now - 48'($urandom_range(0, 50000)),
					4'd0, 32'd0, 1'b0);
			end else if (r < 72) begin
				add_op(fstwa_pkg::FUNC_SCHEDULE, 48'({$urandom, $urandom}), 4'($urandom),
					($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 80000),
					1'($urandom));
			end else if (r < 92) begin
				add_op(fstwa_pkg::FUNC_UNSCHED, 48'({$urandom, $urandom}), 4'($urandom),
					$urandom, 1'($urandom));
			end else begin
				add_op(fstwa_pkg::FUNC_RESET, gen_now, 4'($urandom), $urandom, 1'($urandom));
			end
		end
	endfunction

	// A quiet advance produces nothing, so allow for its scan before touching config.
	task automatic wait_idle();
		do @(posedge clk);
		while (op_pending.size() != 0 || s_axis_tvalid || results_due.size() != 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_interval(logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 0;
		m_interval = v;
	endtask

	initial begin
		logic [31:0] phase_ivl [5];
		phase_ivl = '{32'd1000, 32'd1, 32'd0, 32'hFFFFFFFF, 32'd16667};
		foreach (m_used[i]) begin
			m_used[i] = 0; m_fired[i] = 0; m_rep[i] = 0; m_stime[i] = 0; m_lfire[i] = 0;
		end
		m_accum = 0; m_elapsed = 0; m_prev_raw = 0; m_base = 0; m_ticks = 0;
		m_interval = 32'd16667;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// Directed: time before the reset base, one-shot and repeating alarms,
		// deadline overflow, overwrite, unschedule hits and misses, full-range times.
		add_op(fstwa_pkg::FUNC_RESET, 48'd1000, 4'd9, 32'd5, 1);
		add_op(fstwa_pkg::FUNC_ADVANCE, 48'd0, 0, 0, 0);
		add_op(fstwa_pkg::FUNC_SCHEDULE, 0, 4'd0, 32'd0, 0);
		add_op(fstwa_pkg::FUNC_SCHEDULE, 0, 4'd15, 32'd5000, 1);
		add_op(fstwa_pkg::FUNC_SCHEDULE, 0, 4'd3, 32'hFFFFFFFF, 0);
		add_op(fstwa_pkg::FUNC_UNSCHED, 0, 4'd7, 0, 0);
		add_op(fstwa_pkg::FUNC_ADVANCE, 48'd20000, 0, 0, 0);
		add_op(fstwa_pkg::FUNC_ADVANCE, 48'd40000, 0, 0, 0);
		add_op(fstwa_pkg::FUNC_SCHEDULE, 0, 4'd0, 32'd100, 1);
		add_op(fstwa_pkg::FUNC_SCHEDULE, 0, 4'd0, 32'd10, 0);
		add_op(fstwa_pkg::FUNC_ADVANCE, 48'd45000, 0, 0, 0);
		add_op(fstwa_pkg::FUNC_RESET, 48'd30000, 0, 0, 0);
		add_op(fstwa_pkg::FUNC_ADVANCE, 48'd60000, 0, 0, 0);
		add_op(fstwa_pkg::FUNC_UNSCHED, 0, 4'd15, 0, 0);
		add_op(fstwa_pkg::FUNC_UNSCHED, 0, 4'd15, 0, 0);
		add_op(fstwa_pkg::FUNC_ADVANCE, fstwa_pkg::MAX48, 0, 0, 0);
		add_op(fstwa_pkg::FUNC_SCHEDULE, fstwa_pkg::MAX48, 4'd5, 32'hFFFFFFFF, 0);
		add_op(fstwa_pkg::FUNC_ADVANCE, fstwa_pkg::MAX48, 0, 0, 0);
		add_op(fstwa_pkg::FUNC_ADVANCE, 48'd0, 4'hF, 32'hFFFFFFFF, 1);
		add_op(fstwa_pkg::FUNC_RESET, 48'd0, 0, 0, 0);
		wait_idle();

		foreach (phase_ivl[p]) begin
			write_interval(phase_ivl[p]);
			no_idle = (p == 2);
			add_random_ops(26);
			wait_idle();
		end

		if (results_due.size() == 0 && fail_count == 0) begin
			$display("tb_fixed_step_timer_with_alarms_top passed");
		end else begin
			$display("tb_fixed_step_timer_with_alarms_top failed");
		end
		$finish;
	end
endmodule
